>>> rtl/differential_drive_odometry_unit_assert.svh
// Assertion macros used by the RTL controller.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define DDO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ddo assertion failed");

// Next-cycle implication, disabled in reset.
`define DDO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ddo assertion failed");

`endif

>>> rtl/ddo_pkg.sv
package ddo_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int FRACTION_BITS = 16;

    localparam int IW = $clog2(CORDIC_STEPS);
    localparam int CW = FRACTION_BITS + 4;
    localparam int ZW = 34;

    localparam logic [63:0] CORDIC_GAIN_Q32 = 64'd2608131496;
    localparam logic [63:0] X0_FULL =
        (CORDIC_GAIN_Q32 + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);
    localparam logic signed [CW-1:0] X0 = CW'(X0_FULL);

    localparam logic [31:0] ATAN_TAB [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic [2:0] REG_DPP     = 3'd0;
    localparam logic [2:0] REG_GAIN    = 3'd1;
    localparam logic [2:0] REG_START_X = 3'd2;
    localparam logic [2:0] REG_START_Y = 3'd3;
    localparam logic [2:0] REG_START_H = 3'd4;

    typedef struct packed {
        logic               op;
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [31:0] heading;
    } t_out;

    typedef struct packed {
        logic          capture;
        logic          prep;
        logic          iter;
        logic          mul;
        logic          acc;
        logic          load_out;
        logic [IW-1:0] iter_idx;
    } t_cmd;

    typedef struct packed {
        logic op;
    } t_sts;

endpackage

>>> rtl/ddo_ctrl.sv
`include "differential_drive_odometry_unit_assert.svh"

module ddo_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ddo_pkg::t_cmd o_cmd,
    input  ddo_pkg::t_sts i_sts
);
    import ddo_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PREP, S_ITER, S_MUL, S_ACC, S_DONE} t_state;

    t_state        r_state;
    logic [IW-1:0] r_iter;
    logic          r_out_valid;
    logic          accept;
    logic          slot_free;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = accept;
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.iter     = (r_state == S_ITER);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.acc      = (r_state == S_ACC);
        o_cmd.load_out = (r_state == S_DONE) && slot_free;
        o_cmd.iter_idx = r_iter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_iter  <= '0;
                    r_state <= i_sts.op ? S_DONE : S_ITER;
                end
                S_ITER: begin
                    if (r_iter == IW'(CORDIC_STEPS - 1)) begin
                        r_state <= S_MUL;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                    end
                end
                S_MUL:  r_state <= S_ACC;
                S_ACC:  r_state <= S_DONE;
                S_DONE: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `DDO_ASSERT_NEXT(a_accept_busy, accept, r_state == S_PREP)
    `DDO_ASSERT_NEXT(a_done_shows, (r_state == S_DONE) && slot_free, r_out_valid)
    `DDO_ASSERT_NOW(a_iter_range, r_state == S_ITER, r_iter <= IW'(CORDIC_STEPS - 1))

endmodule

>>> rtl/ddo_datapath.sv
module ddo_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  ddo_pkg::t_in  i_in,
    output ddo_pkg::t_out o_out,
    input  ddo_pkg::t_cmd i_cmd,
    output ddo_pkg::t_sts o_sts
);
    import ddo_pkg::*;

    logic [15:0] r_dpp;
    logic [31:0] r_gain, r_start_x, r_start_y, r_start_h;
    logic [31:0] r_last_l, r_last_r, r_x_acc, r_y_acc, r_h_acc;
    t_in         r_in;

    logic signed [31:0]     r_mean;
    logic signed [32:0]     r_diff;
    logic signed [CW-1:0]   r_cx, r_cy;
    logic signed [ZW-1:0]   r_z;
    logic                   r_flip;
    logic signed [31+CW:0]  r_px, r_py;
    logic signed [65:0]     r_ph;

    logic signed [31:0]   dl, dr, tl, tr;
    logic signed [32:0]   tsum;
    logic signed [47:0]   ml, mr;
    logic [31:0]          qoff, ang;
    logic signed [CW-1:0] sx, sy, cx_f, cy_f;
    logic signed [ZW-1:0] atan_z;

    always_comb begin
        dl   = $signed(r_in.left_count - r_last_l);
        dr   = $signed(r_in.right_count - r_last_r);
        ml   = 48'(dl) * $signed({32'd0, r_dpp});
        mr   = 48'(dr) * $signed({32'd0, r_dpp});
        tl   = ml[31:0];
        tr   = mr[31:0];
        tsum = 33'(tl) + 33'(tr);
        qoff = r_h_acc + 32'h40000000;
        ang  = qoff[31] ? (r_h_acc + 32'h80000000) : r_h_acc;
        sx   = r_cx >>> i_cmd.iter_idx;
        sy   = r_cy >>> i_cmd.iter_idx;
        atan_z = $signed({{(ZW-32){1'b0}}, ATAN_TAB[i_cmd.iter_idx]});
        cx_f = r_flip ? -r_cx : r_cx;
        cy_f = r_flip ? -r_cy : r_cy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpp     <= 16'd824;
            r_gain    <= 32'd2531700000;
            r_start_x <= '0;
            r_start_y <= '0;
            r_start_h <= '0;
            r_last_l  <= '0;
            r_last_r  <= '0;
            r_x_acc   <= '0;
            r_y_acc   <= '0;
            r_h_acc   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DPP:     r_dpp     <= i_cfg_data[15:0];
                    REG_GAIN:    r_gain    <= i_cfg_data;
                    REG_START_X: r_start_x <= i_cfg_data;
                    REG_START_Y: r_start_y <= i_cfg_data;
                    REG_START_H: r_start_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.prep) begin
                r_last_l <= r_in.left_count;
                r_last_r <= r_in.right_count;
                if (r_in.op) begin
                    r_x_acc <= r_start_x;
                    r_y_acc <= r_start_y;
                    r_h_acc <= r_start_h;
                end
            end
            if (i_cmd.acc) begin
                r_x_acc <= r_x_acc + r_px[FRACTION_BITS +: 32];
                r_y_acc <= r_y_acc + r_py[FRACTION_BITS +: 32];
                r_h_acc <= r_h_acc + r_ph[55:24];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in;
        end
        if (i_cmd.prep) begin
            r_mean <= tsum[32:1];
            r_diff <= 33'(tr) - 33'(tl);
            r_cx   <= X0;
            r_cy   <= '0;
            r_z    <= ZW'($signed(ang));
            r_flip <= qoff[31];
        end
        if (i_cmd.iter) begin
            if (!r_z[ZW-1]) begin
                r_cx <= r_cx - sy;
                r_cy <= r_cy + sx;
                r_z  <= r_z - atan_z;
            end else begin
                r_cx <= r_cx + sy;
                r_cy <= r_cy - sx;
                r_z  <= r_z + atan_z;
            end
        end
        if (i_cmd.mul) begin
            r_px <= (32+CW)'(r_mean) * (32+CW)'(cx_f);
            r_py <= (32+CW)'(r_mean) * (32+CW)'(cy_f);
            r_ph <= 66'(r_diff) * $signed({34'd0, r_gain});
        end
        if (i_cmd.load_out) begin
            o_out.pos_x   <= r_x_acc;
            o_out.pos_y   <= r_y_acc;
            o_out.heading <= r_h_acc;
        end
    end

    assign o_sts.op = r_in.op;

endmodule

>>> rtl/differential_drive_odometry_unit.sv
// Differential-drive odometry. Each transfer is a wheel-count sample or a
// restart and yields one pose. A sample goes through prep, the iterative
// CORDIC, which does one rotation a cycle, then multiply and accumulate;
// a restart goes from prep straight to the result. One item is in work at a
// time; the result register lets the next item in while a pose waits.
// Configuration writes are always ready and must only be made while idle.
module differential_drive_odometry_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ddo_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ddo_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import ddo_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    ddo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ddo_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

>>> sim/tb_differential_drive_odometry_unit.sv
`timescale 1ns / 1ps

module tb_differential_drive_odometry_unit;
    import ddo_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    differential_drive_odometry_unit uut (.*);

    // predictor state
    logic [15:0] dpp;
    logic [31:0] gain, sx, sy, sh;
    logic [31:0] last_l, last_r, x_acc, y_acc, h_acc;

    t_in  pending_items[$];
    t_out expected_poses[$];
    int   errors;
    bit   idle_en;
    int   hold_cnt;
    bit   in_fired;
    int   sent_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void cos_sin(logic [31:0] ang, output longint c, output longint s);
        bit flip;
        longint x, y, z, nx;
        logic [31:0] q;
        q = ang + 32'h4000_0000;
        flip = q[31];
        if (flip) ang = ang + 32'h8000_0000;
        z = longint'($signed(ang));
        x = longint'((64'd2608131496 + (64'd1 << (31 - FRACTION_BITS)))
                     >> (32 - FRACTION_BITS));
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - floor_sh(y, i);
                y  = y + floor_sh(x, i);
                z  = z - longint'(ATAN_TAB[i]);
            end else begin
                nx = x + floor_sh(y, i);
                y  = y - floor_sh(x, i);
                z  = z + longint'(ATAN_TAB[i]);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic t_out advance_pose(t_in it);
        t_out r;
        longint dl, dr, tl, tr, mean, c, s;
        logic [63:0] prod, mx, my;
        logic [31:0] d32;
        if (it.op) begin
            x_acc = sx;
            y_acc = sy;
            h_acc = sh;
        end else begin
            d32 = it.left_count - last_l;
            dl = longint'($signed(d32));
            d32 = it.right_count - last_r;
            dr = longint'($signed(d32));
            d32 = 32'(dl * longint'(dpp));
            tl = longint'($signed(d32));
            d32 = 32'(dr * longint'(dpp));
            tr = longint'($signed(d32));
            mean = (tl + tr) >>> 1;
            cos_sin(h_acc, c, s);
            mx = 64'(floor_sh(mean * c, FRACTION_BITS));
            my = 64'(floor_sh(mean * s, FRACTION_BITS));
            x_acc = x_acc + mx[31:0];
            y_acc = y_acc + my[31:0];
            prod = 64'(tr - tl) * {32'd0, gain};
            h_acc = h_acc + prod[55:24];
        end
        last_l = it.left_count;
        last_r = it.right_count;
        r.pos_x = x_acc;
        r.pos_y = y_acc;
        r.heading = h_acc;
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fired) begin
        end else if (pending_items.size() > 0 && !(idle_en && $urandom_range(99) < 29)) begin
            i_in_valid <= 1'b1;
            i_in <= pending_items.pop_front();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        in_fired = i_rst_n && i_in_valid && !o_in_stall;
        if (in_fired) begin
            expected_poses.push_back(advance_pose(i_in));
            sent_count++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cnt > 0) begin
            i_out_stall <= 1'b1;
            hold_cnt--;
        end else begin
            i_out_stall <= idle_en && $urandom_range(99) < 29;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_poses.size() == 0) begin
                $error("unexpected transfer: %h", o_out);
                errors++;
            end else begin
                e = expected_poses.pop_front();
                if (o_out.pos_x !== e.pos_x) begin
                    $error("pos_x expected %h actual %h", e.pos_x, o_out.pos_x);
                    errors++;
                end
                if (o_out.pos_y !== e.pos_y) begin
                    $error("pos_y expected %h actual %h", e.pos_y, o_out.pos_y);
                    errors++;
                end
                if (o_out.heading !== e.heading) begin
                    $error("heading expected %h actual %h", e.heading, o_out.heading);
                    errors++;
                end
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_DPP:     dpp  = val[15:0];
            REG_GAIN:    gain = val;
            REG_START_X: sx   = val;
            REG_START_Y: sy   = val;
            REG_START_H: sh   = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        while (pending_items.size() > 0 || i_in_valid || expected_poses.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic t_in mk(bit op, logic [31:0] l, logic [31:0] r);
        t_in t;
        t.op = op;
        t.left_count = l;
        t.right_count = r;
        return t;
    endfunction

    task automatic queue_walk(int n);
        logic [31:0] l, r;
        l = $urandom;
        r = l + $urandom_range(200);
        pending_items.push_back(mk(1'b1, l, r));
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: begin
                    l = $urandom;
                    r = $urandom;
                end
                1: pending_items.push_back(mk(1'b1, $urandom, $urandom));
                default: begin
                    l = l + 32'($urandom_range(400)) - 32'd200;
                    r = r + 32'($urandom_range(400)) - 32'd200;
                end
            endcase
            pending_items.push_back(mk(1'b0, l, r));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        idle_en = 1'b0;
        hold_cnt = 0;
        in_fired = 1'b0;
        errors = 0;
        sent_count = 0;
        dpp = 16'd824;
        gain = 32'd2531700000;
        sx = '0;
        sy = '0;
        sh = '0;
        last_l = '0;
        last_r = '0;
        x_acc = '0;
        y_acc = '0;
        h_acc = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings
        pending_items.push_back(mk(1'b0, 32'd100, 32'd100));
        pending_items.push_back(mk(1'b0, 32'd150, 32'd300));
        pending_items.push_back(mk(1'b0, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_items.push_back(mk(1'b0, 32'h8000_0000, 32'h7FFF_FFFF));
        pending_items.push_back(mk(1'b0, 32'hFFFF_FFFF, 32'h0000_0000));
        pending_items.push_back(mk(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_items.push_back(mk(1'b0, 32'h0, 32'h0));
        drain();

        cfg_write(REG_DPP, 32'h0000_FFFF);
        cfg_write(REG_GAIN, 32'hFFFF_FFFF);
        cfg_write(REG_START_X, 32'h7FFF_FFFF);
        cfg_write(REG_START_Y, 32'h8000_0000);
        cfg_write(REG_START_H, 32'hC000_0000);
        cfg_write(3'd7, 32'h1234_5678);
        pending_items.push_back(mk(1'b1, 32'd0, 32'd0));
        pending_items.push_back(mk(1'b0, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_items.push_back(mk(1'b0, 32'h8000_0000, 32'h8000_0000));
        pending_items.push_back(mk(1'b0, 32'h0, 32'h7FFF_FFFF));
        pending_items.push_back(mk(1'b1, 32'h5555_5555, 32'hAAAA_AAAA));
        for (int a = 0; a < 8; a++) begin
            drain();
            cfg_write(REG_START_H, 32'(a) << 29 | 32'h0100_0000);
            pending_items.push_back(mk(1'b1, 32'd0, 32'd0));
            pending_items.push_back(mk(1'b0, 32'd10, 32'd10));
        end
        drain();

        cfg_write(REG_DPP, 32'd0);
        cfg_write(REG_GAIN, 32'd0);
        pending_items.push_back(mk(1'b0, $urandom, $urandom));
        pending_items.push_back(mk(1'b0, $urandom, $urandom));
        drain();

        // random phases
        idle_en = 1'b1;
        for (int ph = 0; ph < 7; ph++) begin
            cfg_write(REG_DPP, (ph == 1) ? 32'hFFFF : $urandom_range(4000));
            cfg_write(REG_GAIN, (ph == 2) ? 32'hFFFF_FFFF : $urandom);
            cfg_write(REG_START_X, $urandom);
            cfg_write(REG_START_Y, $urandom);
            cfg_write(REG_START_H, $urandom);
            if (ph == 3) idle_en = 1'b0;
            queue_walk(230);
            if (ph == 4) hold_cnt = HOLD_CYCLES;
            drain();
            idle_en = 1'b1;
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_poses.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/ddo_pkg.sv
rtl/ddo_ctrl.sv
rtl/ddo_datapath.sv
rtl/differential_drive_odometry_unit.sv
sim/tb_differential_drive_odometry_unit.sv
